// File: rtl/assert_macros.svh
// Assertion helpers shared by the timer block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define RCT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that cons holds in the cycle after ante.
`define RCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/rctmr_pkg.sv
`timescale 1ns / 1ps

package rctmr_pkg;

  localparam int TIMER_COUNT      = 3;
  localparam int PRESCALE_DIV_DEF = 8;

  localparam int ACTION_W = 3;
  localparam int CYCLES_W = 12;
  localparam int ADDR_W   = 6;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = 32;
  localparam int TGT_W    = 16;
  localparam int SEL_W    = 2;
  localparam int OFF_W    = 4;

  localparam int S_TDATA_W = 56;
  localparam int M_TDATA_W = 40;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK         = 3'd0,
    ACT_HBLANK_START = 3'd1,
    ACT_HBLANK_END   = 3'd2,
    ACT_VBLANK_START = 3'd3,
    ACT_VBLANK_END   = 3'd4,
    ACT_READ         = 3'd5,
    ACT_WRITE        = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    SYNC_PAUSE     = 2'b00,
    SYNC_RESET     = 2'b01,
    SYNC_RESET_RUN = 2'b10,
    SYNC_FREE_ONCE = 2'b11
  } sync_t;

  localparam logic [OFF_W-1:0] OFF_COUNTER = 4'h0;
  localparam logic [OFF_W-1:0] OFF_MODE    = 4'h4;
  localparam logic [OFF_W-1:0] OFF_TARGET  = 4'h8;

  localparam int MB_SYNC_EN  = 0;
  localparam int MB_SYNC_LO  = 1;
  localparam int MB_RESET    = 3;
  localparam int MB_IRQ_TGT  = 4;
  localparam int MB_IRQ_MAX  = 5;
  localparam int MB_ONESHOT  = 6;
  localparam int MB_SRC0     = 8;
  localparam int MB_SRC1     = 9;
  localparam int MB_IRQ      = 10;
  localparam int MB_HIT_TGT  = 11;
  localparam int MB_HIT_MAX  = 12;

  localparam logic [CNT_W-1:0] CNT_MAX = 32'h0000_FFFF;

  typedef struct packed {
    logic                tick;
    logic                hclk;
    logic                blank_start;
    logic                blank_end;
    logic                wr_counter;
    logic                wr_mode;
    logic                wr_target;
    logic                src0_hold;
    logic                src1_scale;
    logic [CYCLES_W-1:0] cycles;
    logic [CYCLES_W-1:0] scaled;
    logic [DATA_W-1:0]   wdata;
  } tmr_ctl_t;

  typedef struct packed {
    logic [CNT_W-1:0]  counter;
    logic [DATA_W-1:0] mode;
    logic [TGT_W-1:0]  target;
  } tmr_stat_t;

endpackage

// File: rtl/three_channel_root_counter_timer.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tuser: action; tdata: tick_cycles, bus_address, write_data
// m_*      out  m_tvalid/m_tready  tdata: read_data, irq_pulse
//
// One request per cycle is taken while s_tready is high; the result register loads when the input register advances.
// The input register also holds tick_cycles / PRESCALE_DIV from a reciprocal multiply.
// Timer update, read mux and compares are combinational from input register to result register.
// Synchronous reset clears all counters, targets, modes and pause flags.
// A stalled result holds the input register; s_tready drops only when both are full.

module three_channel_root_counter_timer import rctmr_pkg::*; #(
  parameter int PRESCALE_DIV = PRESCALE_DIV_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // [11:0] tick_cycles, [17:12] bus_address, [49:18] write_data, rest zero
  input  logic [S_TDATA_W-1:0] s_tdata,
  // [2:0] action
  input  logic [ACTION_W-1:0]  s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [31:0] read_data, [34:32] irq_pulse, rest zero
  output logic [M_TDATA_W-1:0] m_tdata
);

  localparam int DIV_SHIFT = CYCLES_W + $clog2(PRESCALE_DIV);
  localparam int DIV_MULT  = ((1 << DIV_SHIFT) + PRESCALE_DIV - 1) / PRESCALE_DIV;
  localparam int PROD_W    = CYCLES_W + CYCLES_W + 2;
  localparam int PAD_W     = M_TDATA_W - DATA_W - TIMER_COUNT;

  logic [CYCLES_W-1:0] in_cycles;
  logic [ADDR_W-1:0]   in_addr;
  logic [DATA_W-1:0]   in_wdata;
  logic [PROD_W-1:0]   prod;
  logic [CYCLES_W-1:0] in_scaled;

  logic                s1_valid;
  action_t             s1_action;
  logic [CYCLES_W-1:0] s1_cycles;
  logic [CYCLES_W-1:0] s1_scaled;
  logic [ADDR_W-1:0]   s1_addr;
  logic [DATA_W-1:0]   s1_wdata;

  logic                   advance;
  logic [SEL_W-1:0]       sel;
  logic [OFF_W-1:0]       off;
  logic [DATA_W-1:0]      rdata;
  logic [TIMER_COUNT-1:0] irq;
  tmr_stat_t              stat [TIMER_COUNT];

  logic                   out_valid;
  logic [DATA_W-1:0]      out_rdata;
  logic [TIMER_COUNT-1:0] out_irq;

  assign in_cycles = s_tdata[CYCLES_W-1:0];
  assign in_addr   = s_tdata[CYCLES_W +: ADDR_W];
  assign in_wdata  = s_tdata[CYCLES_W + ADDR_W +: DATA_W];
  assign prod      = PROD_W'(in_cycles) * PROD_W'(DIV_MULT);
  assign in_scaled = CYCLES_W'(prod >> DIV_SHIFT);

  assign advance  = s1_valid && (!out_valid || m_tready);
  assign s_tready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_action <= action_t'(s_tuser);
      s1_cycles <= in_cycles;
      s1_scaled <= in_scaled;
      s1_addr   <= in_addr;
      s1_wdata  <= in_wdata;
    end
  end

  assign sel = s1_addr[ADDR_W-1 -: SEL_W];
  assign off = s1_addr[OFF_W-1:0];

  for (genvar g = 0; g < TIMER_COUNT; g++) begin : g_tmr
    tmr_ctl_t ctl;

    always_comb begin
      ctl            = '0;
      ctl.cycles     = s1_cycles;
      ctl.scaled     = s1_scaled;
      ctl.wdata      = s1_wdata;
      ctl.src0_hold  = (g == 1);
      ctl.src1_scale = (g == 2);
      if (advance) begin
        case (s1_action)
          ACT_TICK: begin
            ctl.tick = 1'b1;
          end
          ACT_HBLANK_START: begin
            ctl.hclk        = (g == 1);
            ctl.blank_start = (g == 0);
          end
          ACT_HBLANK_END: begin
            ctl.blank_end = (g == 0);
          end
          ACT_VBLANK_START: begin
            ctl.blank_start = (g == 1);
          end
          ACT_VBLANK_END: begin
            ctl.blank_end = (g == 1);
          end
          ACT_WRITE: begin
            if (sel == SEL_W'(g)) begin
              ctl.wr_counter = (off == OFF_COUNTER);
              ctl.wr_mode    = (off == OFF_MODE);
              ctl.wr_target  = (off == OFF_TARGET);
            end
          end
          default: begin
          end
        endcase
      end
    end

    rctmr_timer u_timer (
      .clk  (clk),
      .rst  (rst),
      .ctl  (ctl),
      .stat (stat[g]),
      .irq  (irq[g])
    );
  end

  always_comb begin
    rdata = '0;
    if (s1_action == ACT_READ && int'(sel) < TIMER_COUNT) begin
      case (off)
        OFF_COUNTER: rdata = DATA_W'(stat[sel].counter[TGT_W-1:0]);
        OFF_MODE:    rdata = stat[sel].mode;
        OFF_TARGET:  rdata = DATA_W'(stat[sel].target);
        default:     rdata = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rdata <= rdata;
      out_irq   <= irq;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{PAD_W{1'b0}}, out_irq, out_rdata};

  `RCT_ASSERT_NEXT(a_irq_tick_only, advance && (s1_action != ACT_TICK), out_irq == '0, "irq pulse on a non-tick request")
  `RCT_ASSERT_NEXT(a_rdata_read_only, advance && (s1_action != ACT_READ), out_rdata == '0, "read data on a non-read request")
  `RCT_ASSERT(a_ready_low_full, !s_tready |-> (s1_valid && out_valid && !m_tready), "input stalled without a full pipeline")

endmodule

// File: rtl/rctmr_timer.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rctmr_timer import rctmr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  tmr_ctl_t  ctl,
  output tmr_stat_t stat,
  output logic      irq
);

  logic [CNT_W-1:0]  counter, counter_next;
  logic [DATA_W-1:0] mode, mode_next;
  logic [TGT_W-1:0]  target, target_next;
  logic              paused, paused_next;
  logic [CNT_W-1:0]  add;

  always_comb begin
    counter_next = counter;
    mode_next    = mode;
    target_next  = target;
    paused_next  = paused;
    irq          = 1'b0;

    add = CNT_W'(ctl.cycles);
    if (ctl.src0_hold && mode[MB_SRC0]) begin
      add = '0;
    end
    if (ctl.src1_scale && mode[MB_SRC1]) begin
      add = CNT_W'(ctl.scaled);
    end

    if (ctl.tick && !paused) begin
      counter_next = counter + add;
      if (counter_next >= CNT_W'(target)) begin
        mode_next[MB_HIT_TGT] = 1'b1;
        if (mode_next[MB_IRQ_TGT]) begin
          mode_next[MB_IRQ] = 1'b1;
          if (mode_next[MB_ONESHOT]) begin
            mode_next[MB_IRQ_TGT] = 1'b0;
            mode_next[MB_IRQ_MAX] = 1'b0;
          end
          irq = 1'b1;
        end
        if (mode_next[MB_RESET]) begin
          counter_next = '0;
        end
      end
      if (counter_next >= CNT_MAX) begin
        mode_next[MB_HIT_MAX] = 1'b1;
        if (mode_next[MB_IRQ_MAX]) begin
          mode_next[MB_IRQ] = 1'b1;
          if (mode_next[MB_ONESHOT]) begin
            mode_next[MB_IRQ_TGT] = 1'b0;
            mode_next[MB_IRQ_MAX] = 1'b0;
          end
          irq = 1'b1;
        end
        if (!mode_next[MB_RESET]) begin
          counter_next = '0;
        end
      end
    end

    if (ctl.hclk && mode[MB_SRC0] && !paused) begin
      counter_next = counter + CNT_W'(1);
    end

    if (ctl.blank_start && mode[MB_SYNC_EN]) begin
      case (sync_t'(mode[MB_SYNC_LO +: 2]))
        SYNC_PAUSE: begin
          paused_next = 1'b1;
        end
        SYNC_RESET: begin
          counter_next = '0;
        end
        SYNC_RESET_RUN: begin
          counter_next = '0;
          paused_next  = 1'b0;
        end
        default: begin
          paused_next           = 1'b0;
          mode_next[MB_SYNC_EN] = 1'b0;
        end
      endcase
    end

    if (ctl.blank_end && mode[MB_SYNC_EN]) begin
      case (sync_t'(mode[MB_SYNC_LO +: 2]))
        SYNC_PAUSE: begin
          paused_next = 1'b0;
        end
        SYNC_RESET_RUN: begin
          paused_next = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (ctl.wr_counter) begin
      counter_next = CNT_W'(ctl.wdata[TGT_W-1:0]);
    end
    if (ctl.wr_mode) begin
      mode_next = ctl.wdata;
    end
    if (ctl.wr_target) begin
      target_next = ctl.wdata[TGT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
      mode    <= '0;
      target  <= '0;
      paused  <= 1'b0;
    end else begin
      counter <= counter_next;
      mode    <= mode_next;
      target  <= target_next;
      paused  <= paused_next;
    end
  end

  assign stat.counter = counter;
  assign stat.mode    = mode;
  assign stat.target  = target;

  `RCT_ASSERT_NEXT(a_irq_sets_flag, irq, mode[MB_IRQ], "irq raised without mode irq flag")
  `RCT_ASSERT_NEXT(a_tick_below_max, ctl.tick && !paused, counter < CNT_MAX, "counter left at max after tick")
  `RCT_ASSERT(a_irq_only_tick, irq |-> ctl.tick, "irq raised outside a tick")

endmodule

// File: bench/three_channel_root_counter_timer_tb.sv
`timescale 1ns / 1ps

module three_channel_root_counter_timer_tb;
  import rctmr_pkg::*;

  localparam int CLK_HALF         = 6;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int HOLD_OFF_CYCLES  = 300;
  localparam int DRAIN_CYCLES     = 8;
  localparam int RANDOM_PER_PHASE = 280;
  localparam int PRESSURE_ITEMS   = 40;

  localparam int SEL_NONE = 3;
  localparam logic [OFF_W-1:0] OFF_UNUSED = 4'hC;

  localparam logic [DATA_W-1:0] MODE_RESET   = 32'd1 << MB_RESET;
  localparam logic [DATA_W-1:0] MODE_IRQ_TGT = 32'd1 << MB_IRQ_TGT;
  localparam logic [DATA_W-1:0] MODE_IRQ_MAX = 32'd1 << MB_IRQ_MAX;
  localparam logic [DATA_W-1:0] MODE_ONESHOT = 32'd1 << MB_ONESHOT;
  localparam logic [DATA_W-1:0] MODE_SRC0    = 32'd1 << MB_SRC0;

  localparam int IRQ_LSB = DATA_W;
  localparam int PAD_LSB = DATA_W + TIMER_COUNT;

  typedef struct packed {
    action_t             act;
    logic [CYCLES_W-1:0] cycles;
    logic [ADDR_W-1:0]   addr;
    logic [DATA_W-1:0]   wdata;
  } timer_request_t;

  typedef struct packed {
    logic [DATA_W-1:0]      read_data;
    logic [TIMER_COUNT-1:0] irq_pulse;
  } timer_response_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic [ACTION_W-1:0]  s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;

  // timer state as seen from the bus
  logic [CNT_W-1:0]  tmr_count  [TIMER_COUNT];
  logic [TGT_W-1:0]  tmr_target [TIMER_COUNT];
  logic [DATA_W-1:0] tmr_mode   [TIMER_COUNT];
  logic              tmr_paused [TIMER_COUNT];

  timer_response_t expected_responses[$];

  int   gap_pct = 0;
  int   stall_pct = 0;
  logic hold_off_request = 1'b0;
  int   mismatches = 0;
  int   results_checked = 0;
  int   irq_results = 0;
  int   idle_cycles = 0;
  int   action_count [8];

  three_channel_root_counter_timer #(
    .PRESCALE_DIV(PRESCALE_DIV_DEF)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic logic [DATA_W-1:0] sync_bits(input sync_t mode);
    return (32'd1 << MB_SYNC_EN) | (DATA_W'(mode) << MB_SYNC_LO);
  endfunction

  function automatic logic [ADDR_W-1:0] bus_addr(input int sel, input logic [OFF_W-1:0] off);
    return {SEL_W'(sel), off};
  endfunction

  function automatic void raise_timer_irq(input int t);
    tmr_mode[t][MB_IRQ] = 1'b1;
    if (tmr_mode[t][MB_ONESHOT]) begin
      tmr_mode[t][MB_IRQ_TGT] = 1'b0;
      tmr_mode[t][MB_IRQ_MAX] = 1'b0;
    end
  endfunction

  function automatic logic tick_timer(input int t, input logic [CYCLES_W-1:0] cycles);
    logic [CNT_W-1:0] step;
    logic raised;
    raised = 1'b0;
    if (tmr_paused[t]) return 1'b0;
    step = CNT_W'(cycles);
    if (t == 1 && tmr_mode[t][MB_SRC0]) step = '0;
    if (t == 2 && tmr_mode[t][MB_SRC1]) step = CNT_W'(cycles / PRESCALE_DIV_DEF);
    tmr_count[t] = tmr_count[t] + step;
    if (tmr_count[t] >= CNT_W'(tmr_target[t])) begin
      tmr_mode[t][MB_HIT_TGT] = 1'b1;
      if (tmr_mode[t][MB_IRQ_TGT]) begin
        raise_timer_irq(t);
        raised = 1'b1;
      end
      if (tmr_mode[t][MB_RESET]) tmr_count[t] = '0;
    end
    if (tmr_count[t] >= CNT_MAX) begin
      tmr_mode[t][MB_HIT_MAX] = 1'b1;
      if (tmr_mode[t][MB_IRQ_MAX]) begin
        raise_timer_irq(t);
        raised = 1'b1;
      end
      if (!tmr_mode[t][MB_RESET]) tmr_count[t] = '0;
    end
    return raised;
  endfunction

  function automatic void sync_on_blank_start(input int t);
    if (tmr_mode[t][MB_SYNC_EN]) begin
      case (sync_t'(tmr_mode[t][MB_SYNC_LO +: 2]))
        SYNC_PAUSE: tmr_paused[t] = 1'b1;
        SYNC_RESET: tmr_count[t] = '0;
        SYNC_RESET_RUN: begin
          tmr_count[t] = '0;
          tmr_paused[t] = 1'b0;
        end
        default: begin
          tmr_paused[t] = 1'b0;
          tmr_mode[t][MB_SYNC_EN] = 1'b0;
        end
      endcase
    end
  endfunction

  function automatic void sync_on_blank_end(input int t);
    if (tmr_mode[t][MB_SYNC_EN]) begin
      case (sync_t'(tmr_mode[t][MB_SYNC_LO +: 2]))
        SYNC_PAUSE: tmr_paused[t] = 1'b0;
        SYNC_RESET_RUN: tmr_paused[t] = 1'b1;
        default: ;
      endcase
    end
  endfunction

  function automatic timer_response_t advance_timers(input timer_request_t req);
    timer_response_t res;
    int sel;
    logic [OFF_W-1:0] off;
    res = '0;
    sel = int'(req.addr[ADDR_W-1 -: SEL_W]);
    off = req.addr[OFF_W-1:0];
    case (req.act)
      ACT_TICK: begin
        for (int t = 0; t < TIMER_COUNT; t++) res.irq_pulse[t] = tick_timer(t, req.cycles);
      end
      ACT_HBLANK_START: begin
        // hblank clocks timer 1 without any compare
        if (tmr_mode[1][MB_SRC0] && !tmr_paused[1]) tmr_count[1] = tmr_count[1] + 1;
        sync_on_blank_start(0);
      end
      ACT_HBLANK_END: sync_on_blank_end(0);
      ACT_VBLANK_START: sync_on_blank_start(1);
      ACT_VBLANK_END: sync_on_blank_end(1);
      ACT_READ: begin
        if (sel < TIMER_COUNT) begin
          case (off)
            OFF_COUNTER: res.read_data = DATA_W'(tmr_count[sel][TGT_W-1:0]);
            OFF_MODE: res.read_data = tmr_mode[sel];
            OFF_TARGET: res.read_data = DATA_W'(tmr_target[sel]);
            default: ;
          endcase
        end
      end
      ACT_WRITE: begin
        if (sel < TIMER_COUNT) begin
          case (off)
            OFF_COUNTER: tmr_count[sel] = CNT_W'(req.wdata[TGT_W-1:0]);
            OFF_MODE: tmr_mode[sel] = req.wdata;
            OFF_TARGET: tmr_target[sel] = req.wdata[TGT_W-1:0];
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic timer_request_t random_request();
    timer_request_t req;
    int pick;
    logic [OFF_W-1:0] off;
    pick = $urandom_range(99);
    req.cycles = CYCLES_W'($urandom);
    req.addr = ADDR_W'($urandom);
    req.wdata = $urandom;
    case ($urandom_range(2))
      0: off = OFF_COUNTER;
      1: off = OFF_MODE;
      default: off = OFF_TARGET;
    endcase
    // mostly valid registers, sometimes any address
    if ($urandom_range(9) != 0) req.addr = bus_addr($urandom_range(TIMER_COUNT - 1), off);
    if (pick < 40) begin
      req.act = ACT_TICK;
      if ($urandom_range(3) == 0) req.cycles = CYCLES_W'($urandom_range(40));
    end else if (pick < 48) begin
      req.act = ACT_HBLANK_START;
    end else if (pick < 54) begin
      req.act = ACT_HBLANK_END;
    end else if (pick < 60) begin
      req.act = ACT_VBLANK_START;
    end else if (pick < 66) begin
      req.act = ACT_VBLANK_END;
    end else if (pick < 84) begin
      req.act = ACT_WRITE;
    end else begin
      req.act = ACT_READ;
    end
    if (req.act == ACT_WRITE) begin
      case (req.addr[OFF_W-1:0])
        OFF_COUNTER: if ($urandom_range(1)) req.wdata[15:0] = 16'hFFFF - 16'($urandom_range(300));
        OFF_TARGET: if ($urandom_range(1)) req.wdata[15:0] = 16'($urandom_range(400));
        default: ;
      endcase
    end
    return req;
  endfunction

  task automatic send_request(input action_t act, input logic [CYCLES_W-1:0] cycles,
                              input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] wdata);
    timer_request_t req;
    req = '{act: act, cycles: cycles, addr: addr, wdata: wdata};
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = act;
    s_tdata = {{(S_TDATA_W - DATA_W - ADDR_W - CYCLES_W){1'b0}}, wdata, addr, cycles};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_responses.push_back(advance_timers(req));
    action_count[act]++;
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic wait_for_drain();
    while (expected_responses.size() != 0) @(negedge clk);
  endtask

  task automatic test_register_access();
    send_request(ACT_WRITE, '0, bus_addr(0, OFF_TARGET), 32'hFFFF_0010);
    send_request(ACT_WRITE, '0, bus_addr(0, OFF_COUNTER), 32'hABCD_FFFE);
    send_request(ACT_READ, '0, bus_addr(0, OFF_COUNTER), '0);
    send_request(ACT_WRITE, '0, bus_addr(SEL_NONE, OFF_COUNTER), '1);
    send_request(ACT_READ, '0, bus_addr(SEL_NONE, OFF_COUNTER), '0);
    send_request(ACT_READ, '0, bus_addr(1, OFF_UNUSED), '0);
    send_request(ACT_WRITE, '0, bus_addr(2, OFF_MODE), '1);
    send_request(ACT_READ, '0, bus_addr(2, OFF_MODE), '0);
  endtask

  task automatic test_target_and_max();
    send_request(ACT_WRITE, '0, bus_addr(0, OFF_MODE), MODE_IRQ_MAX);
    send_request(ACT_TICK, 12'd1, '0, '0);
    send_request(ACT_WRITE, '0, bus_addr(0, OFF_MODE),
                 MODE_RESET | MODE_IRQ_TGT | MODE_IRQ_MAX | MODE_ONESHOT);
    send_request(ACT_TICK, 12'h010, '0, '0);
    send_request(ACT_TICK, '1, '0, '0);
    send_request(ACT_WRITE, '0, bus_addr(1, OFF_MODE), MODE_SRC0 | sync_bits(SYNC_PAUSE));
    send_request(ACT_TICK, '1, '0, '0);
    send_request(ACT_HBLANK_START, '0, '0, '0);
  endtask

  task automatic test_blank_sync();
    send_request(ACT_WRITE, '0, bus_addr(0, OFF_MODE), sync_bits(SYNC_PAUSE));
    send_request(ACT_HBLANK_START, '0, '0, '0);
    send_request(ACT_TICK, 12'd5, '0, '0);
    send_request(ACT_HBLANK_END, '0, '0, '0);
    send_request(ACT_WRITE, '0, bus_addr(0, OFF_MODE), sync_bits(SYNC_RESET));
    send_request(ACT_HBLANK_START, '0, '0, '0);
    send_request(ACT_WRITE, '0, bus_addr(0, OFF_MODE), sync_bits(SYNC_RESET_RUN));
    send_request(ACT_HBLANK_START, '0, '0, '0);
    send_request(ACT_HBLANK_END, '0, '0, '0);
    send_request(ACT_WRITE, '0, bus_addr(0, OFF_MODE), sync_bits(SYNC_FREE_ONCE));
    send_request(ACT_HBLANK_START, '0, '0, '0);
    send_request(ACT_READ, '0, bus_addr(0, OFF_MODE), '0);
    send_request(ACT_VBLANK_START, '0, '0, '0);
    send_request(ACT_HBLANK_START, '0, '0, '0);
    send_request(ACT_VBLANK_END, '0, '0, '0);
    send_request(ACT_READ, '0, bus_addr(1, OFF_COUNTER), '0);
  endtask

  task automatic test_random_traffic(input int gap, input int stall);
    timer_request_t req;
    gap_pct = gap;
    stall_pct = stall;
    repeat (RANDOM_PER_PHASE) begin
      req = random_request();
      send_request(req.act, req.cycles, req.addr, req.wdata);
    end
  endtask

  task automatic test_output_backpressure();
    timer_request_t req;
    gap_pct = 0;
    stall_pct = 0;
    hold_off_request = 1'b1;
    repeat (PRESSURE_ITEMS) begin
      req = random_request();
      send_request(req.act, req.cycles, req.addr, req.wdata);
    end
    wait_for_drain();
  endtask

  // result side: random stalls, plus a long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_request) begin
        m_tready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_request = 1'b0;
      end
      m_tready = ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    timer_response_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_responses.size() == 0) begin
        $error("unexpected response, tdata %h", m_tdata);
        mismatches++;
      end else begin
        want = expected_responses.pop_front();
        results_checked++;
        if (want.irq_pulse != '0) irq_results++;
        if (m_tdata[DATA_W-1:0] !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, m_tdata[DATA_W-1:0]);
          mismatches++;
        end
        if (m_tdata[IRQ_LSB +: TIMER_COUNT] !== want.irq_pulse) begin
          $error("irq_pulse: expected %b, got %b", want.irq_pulse, m_tdata[IRQ_LSB +: TIMER_COUNT]);
          mismatches++;
        end
        if (m_tdata[M_TDATA_W-1:PAD_LSB] !== '0) begin
          $error("pad: expected 0, got %h", m_tdata[M_TDATA_W-1:PAD_LSB]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[three_channel_root_counter_timer] ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    foreach (action_count[a]) action_count[a] = 0;
    for (int t = 0; t < TIMER_COUNT; t++) begin
      tmr_count[t] = '0;
      tmr_target[t] = '0;
      tmr_mode[t] = '0;
      tmr_paused[t] = 1'b0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_register_access();
    test_target_and_max();
    test_blank_sync();
    test_random_traffic(0, 0);
    test_random_traffic(50, 0);
    test_random_traffic(0, 50);
    test_random_traffic(29, 29);
    test_output_backpressure();

    gap_pct = 0;
    stall_pct = 0;
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_responses.size() != 0) mismatches++;

    $display("Run covered %0d ticks, %0d blank events, %0d reads and %0d writes.",
             action_count[ACT_TICK],
             action_count[ACT_HBLANK_START] + action_count[ACT_HBLANK_END] +
             action_count[ACT_VBLANK_START] + action_count[ACT_VBLANK_END],
             action_count[ACT_READ], action_count[ACT_WRITE]);
    $display("%0d responses checked, %0d carried an interrupt, %0d mismatches.",
             results_checked, irq_results, mismatches);
    if (mismatches == 0) begin
      $display("[three_channel_root_counter_timer] OK");
    end else begin
      $display("[three_channel_root_counter_timer] ERROR");
    end
    $finish;
  end

endmodule
